// ===== sv/rfpe_pkg.sv =====
// Shared types and constants for the remote-control pulse encoder.
// Holds the command and result word layouts and the configuration register map.
// No dependencies.
`default_nettype none

package rfpe_pkg;

	localparam int HOME_CODE_W  = 26;
	localparam int UNIT_TICKS_W = 12;
	localparam int REPEAT_W     = 4;
	localparam int CHANNEL_W    = 4;
	localparam int CFG_DATA_W   = 26;
	localparam int CFG_INDEX_W  = 2;

	localparam logic [HOME_CODE_W-1:0]  HOME_CODE_RST  = '0;
	localparam logic [UNIT_TICKS_W-1:0] UNIT_TICKS_RST = 12'd240;
	localparam logic [REPEAT_W-1:0]     REPEAT_RST     = 4'd3;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_HOME_CODE    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNIT_TICKS   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_COUNT = 2'd2;

	typedef struct packed {
		logic                 mode;
		logic                 group;
		logic                 onoff;
		logic [CHANNEL_W-1:0] channel;
	} cmd_word_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic frame_end;
		logic rejected;
	} res_word_t;

	typedef struct packed {
		logic [HOME_CODE_W-1:0]  home_code;
		logic [UNIT_TICKS_W-1:0] unit_ticks;
		logic [REPEAT_W-1:0]     repeat_count;
	} cfg_regs_t;

endpackage

`default_nettype wire

// ===== sv/rfpe_core.sv =====
// Frame sequencer of the remote-control pulse encoder: command word, segment
// phase, bit counter, repeat counter and segment timer. Uses rfpe_pkg.
`default_nettype none

module rfpe_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 step,
	input  rfpe_pkg::cmd_word_t cmd,
	input  rfpe_pkg::cfg_regs_t cfg,
	output rfpe_pkg::res_word_t res
);
	import rfpe_pkg::*;

	localparam int TIME_W = 18;

	typedef enum logic [2:0] {
		PH_LEAD_HIGH = 3'd0,
		PH_LEAD_LOW  = 3'd1,
		PH_BIT_HA    = 3'd2,
		PH_BIT_LA    = 3'd3,
		PH_BIT_HB    = 3'd4,
		PH_BIT_LB    = 3'd5,
		PH_STOP_HIGH = 3'd6,
		PH_STOP_LOW  = 3'd7
	} phase_t;

	logic [31:0]       frame_word_q, frame_word_n;
	phase_t            phase_q, phase_n;
	logic [4:0]        bit_index_q, bit_index_n;
	logic [REPEAT_W-1:0] repeats_q, repeats_n;
	logic [TIME_W-1:0] time_left_q, time_left_n;
	logic              level_q, level_n;

	logic [TIME_W-1:0] unit_len;
	logic [TIME_W-1:0] unit_x5;
	logic              busy;
	logic              enter_en;
	phase_t            enter_ph;

	// A zero unit length behaves as one tick.
	assign unit_len = (cfg.unit_ticks == '0) ? TIME_W'(1) : TIME_W'(cfg.unit_ticks);
	assign unit_x5  = (unit_len << 2) + unit_len;
	assign busy     = (repeats_q != '0);

	always_comb begin
		frame_word_n = frame_word_q;
		phase_n      = phase_q;
		bit_index_n  = bit_index_q;
		repeats_n    = repeats_q;
		time_left_n  = time_left_q;
		level_n      = level_q;
		enter_en     = 1'b0;
		enter_ph     = PH_LEAD_HIGH;
		res          = '0;

		if (cmd.mode) begin
			res.busy_res = 1'b1;
			if (busy) begin
				res.rejected   = 1'b1;
				res.line_level = level_q;
			end else begin
				frame_word_n   = {cfg.home_code, cmd.group, cmd.onoff, ~cmd.channel};
				bit_index_n    = '0;
				repeats_n      = (cfg.repeat_count == '0) ? REPEAT_W'(1) : cfg.repeat_count;
				phase_n        = PH_LEAD_HIGH;
				time_left_n    = unit_len;
				level_n        = 1'b1;
				res.line_level = 1'b1;
			end
		end else if (busy) begin
			res.busy_res   = 1'b1;
			res.line_level = level_q;
			if (time_left_q > TIME_W'(1)) begin
				time_left_n = time_left_q - TIME_W'(1);
			end else begin
				case (phase_q)
					PH_BIT_LB: begin
						frame_word_n = {frame_word_q[30:0], frame_word_q[31]};
						enter_en     = 1'b1;
						if (bit_index_q == 5'd31) begin
							bit_index_n = '0;
							enter_ph    = PH_STOP_HIGH;
						end else begin
							bit_index_n = bit_index_q + 5'd1;
							enter_ph    = PH_BIT_HA;
						end
					end
					PH_STOP_LOW: begin
						repeats_n   = repeats_q - REPEAT_W'(1);
						bit_index_n = '0;
						if (repeats_q == REPEAT_W'(1)) begin
							res.frame_end = 1'b1;
							phase_n       = PH_LEAD_HIGH;
							time_left_n   = '0;
							level_n       = 1'b0;
						end else begin
							enter_en = 1'b1;
							enter_ph = PH_LEAD_HIGH;
						end
					end
					default: begin
						enter_en = 1'b1;
						enter_ph = phase_t'(phase_q + 3'd1);
					end
				endcase
			end
		end

		// Entering a segment loads its length; the data bit is the word's MSB.
		if (enter_en) begin
			phase_n = enter_ph;
			level_n = ~enter_ph[0];
			case (enter_ph)
				PH_LEAD_LOW: time_left_n = unit_x5 << 1;
				PH_BIT_LA:   time_left_n = frame_word_q[31] ? unit_x5 : unit_len;
				PH_BIT_LB:   time_left_n = frame_word_q[31] ? unit_len : unit_x5;
				PH_STOP_LOW: time_left_n = unit_x5 << 3;
				default:     time_left_n = unit_len;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_word_q <= '0;
			phase_q      <= PH_LEAD_HIGH;
			bit_index_q  <= '0;
			repeats_q    <= '0;
			time_left_q  <= '0;
			level_q      <= 1'b0;
		end else if (step) begin
			frame_word_q <= frame_word_n;
			phase_q      <= phase_n;
			bit_index_q  <= bit_index_n;
			repeats_q    <= repeats_n;
			time_left_q  <= time_left_n;
			level_q      <= level_n;
		end
	end

`ifndef ASSERT_OFF
	a_idle_line_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !level_q)
		else $error("line is high while no frame is in progress");

	a_busy_timer_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (time_left_q != '0))
		else $error("segment timer is zero during a frame");

	a_level_follows_phase: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (level_q == ~phase_q[0]))
		else $error("line level disagrees with segment phase");

	a_bit_index_outside_data: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LEAD_HIGH || phase_q == PH_LEAD_LOW ||
		 phase_q == PH_STOP_HIGH || phase_q == PH_STOP_LOW) |-> (bit_index_q == '0))
		else $error("bit counter not cleared outside the data bits");
`endif

endmodule

`default_nettype wire

// ===== sv/rf_remote_pulse_encoder_top.sv =====
// Top level of the remote-control pulse encoder: configuration registers,
// handshake and result register around rfpe_core. Uses rfpe_pkg.
//
// Usage: each word on the cmd channel is either a tick (mode 0), which moves
// the transmitter line forward by one tick, or a send (mode 1), which loads a
// new command word built from the home code, group, on/off and channel bits.
// Every accepted cmd word yields exactly one res word carrying the line level,
// the busy flag, the end-of-last-frame flag and the reject flag.
// The result is registered and shows on res in the next cycle. Throughput is
// one word per cycle while cmd_ready is high; the frame state updates in a
// single pass of the sequencer, so one tick word can follow another directly.
// A result register parts the two channels: cmd_ready stays high while the
// result register is empty or being drained, so a stalled receiver holds off
// new words only once a result is actually waiting.
// Reset clears the frame state (idle, line low), empties the result register
// and loads the default configuration: home code 0, 240 ticks per unit and
// three frames per command. Configuration writes take effect at once and are
// meant for idle periods only; indexes beyond the register list are ignored.
`default_nettype none

module rf_remote_pulse_encoder_top (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cmd_valid,
	output logic                                  cmd_ready,
	input  rfpe_pkg::cmd_word_t                   cmd,
	output logic                                  res_valid,
	input  wire                                   res_ready,
	output rfpe_pkg::res_word_t                   res,
	input  wire                                   cfg_we,
	input  wire [rfpe_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  wire [rfpe_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
	import rfpe_pkg::*;

	cfg_regs_t cfg_q;
	res_word_t res_n;
	res_word_t res_q;
	logic      res_valid_q;
	logic      step;

	// A word is taken whenever the result slot is free or is being emptied.
	assign cmd_ready = !res_valid_q || res_ready;
	assign step      = cmd_valid && cmd_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.home_code    <= HOME_CODE_RST;
			cfg_q.unit_ticks   <= UNIT_TICKS_RST;
			cfg_q.repeat_count <= REPEAT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HOME_CODE:    cfg_q.home_code    <= cfg_wdata[HOME_CODE_W-1:0];
				CFG_UNIT_TICKS:   cfg_q.unit_ticks   <= cfg_wdata[UNIT_TICKS_W-1:0];
				CFG_REPEAT_COUNT: cfg_q.repeat_count <= cfg_wdata[REPEAT_W-1:0];
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	rfpe_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cmd    (cmd),
		.cfg    (cfg_q),
		.res    (res_n)
	);

	// Result register: loaded with each accepted word's result, held on stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_n;
		end
	end

endmodule

`default_nettype wire
